// ----- src/assert_macros.svh -----
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("%m: lbl failed");

// next-cycle implication
`define AST_NXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("%m: lbl failed");

`endif

// ----- src/fepa_pkg.sv -----
package fepa_pkg;

    localparam int QUEUE_DEPTH_DEF    = 1024;
    localparam int RUN_PAGES_MAX_DEF  = 1048576;
    localparam int PHYS_ADDR_BITS_DEF = 48;

    localparam int PG_SHIFT  = 12;
    localparam int LEN_BITS  = 20;
    localparam int FLD_BITS  = 48;
    localparam int TOT_BITS  = 49;
    localparam int STAT_BITS = 3;
    localparam logic [TOT_BITS-1:0] TOTAL_MAX = '1;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK      = 3'd0,
        ST_OOM     = 3'd1,
        ST_MISADDR = 3'd2,
        ST_MISSIZE = 3'd3,
        ST_OVF     = 3'd4
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic {
        RET_FREE,
        RET_ALLOC
    } ret_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_FRUN,
        S_ARD,
        S_ACMP,
        S_CSTART,
        S_SRD0,
        S_SLD0,
        S_SRD,
        S_SCMP,
        S_SEND,
        S_MRD0,
        S_MLD0,
        S_MRD,
        S_MCMP,
        S_MEND,
        S_CDONE,
        S_FIN
    } state_t;

endpackage

// ----- src/free_extent_page_allocator.sv -----
// channel | dir | handshake           | payload
// s       | in  | s_tvalid / s_tready | tuser opcode; tdata region_addr, size_bytes
// m       | out | m_tvalid / m_tready | tdata alloc_addr, status, free_bytes
// One beat in, one beat out. Free appends runs until the size is covered; misaligned frees are rejected.
// Alloc visits extents from the head; a failed first pass runs a compaction and then a retry.
// Compaction: bubble sort through the RAM's one read port and one write port,
// then a merge of adjacent extents. s_tready is high only when idle.
// Reset is asynchronous and empties the queue; the result register holds under stall.
module free_extent_page_allocator
    import fepa_pkg::*;
#(
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
    parameter int RUN_PAGES_MAX  = RUN_PAGES_MAX_DEF,
    parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // region_addr[47:0], size_bytes[95:48]
    input  logic         s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // alloc_addr[47:0], status[50:48], free_bytes[99:51], 0
);

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int PGW = PHYS_ADDR_BITS - PG_SHIFT;
    localparam int EW  = PGW + LEN_BITS;
    localparam int LW  = FLD_BITS - PG_SHIFT;

    state_t state_reg, state_next;

    logic [AW-1:0]       head_reg, head_next, tail_reg, tail_next;
    logic [AW-1:0]       rp_reg, rp_next, wp_reg, wp_next;
    logic [CW-1:0]       count_reg, count_next, i_reg, i_next, n_reg, n_next, k_reg, k_next;
    logic                pass_reg, pass_next, swap_reg, swap_next, tried_reg, tried_next;
    ret_t                ret_reg, ret_next;
    logic [TOT_BITS-1:0] total_reg, total_next;
    logic                mvalid_reg, mvalid_next;

    logic                op_reg, op_next;
    logic [FLD_BITS-1:0] addr_in_reg, addr_in_next, size_reg, size_next;
    logic [LW-1:0]       left_reg, left_next;
    logic [PGW-1:0]      pg_reg, pg_next, cs_reg, cs_next;
    logic [LW:0]         want_reg, want_next;
    status_t             stat_reg, stat_next;
    logic [FLD_BITS-1:0] aout_reg, aout_next;
    logic [EW-1:0]       cur_reg, cur_next;
    logic [LEN_BITS:0]   cl_reg, cl_next;
    logic [FLD_BITS-1:0] mad_reg, mad_next;
    status_t             mst_reg, mst_next;
    logic [TOT_BITS-1:0] mfb_reg, mfb_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    fepa_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // decoded fields
    logic [55:0]       aext, sa56;
    logic [LEN_BITS:0] run, rd_len, rem_len, ml_sum;
    logic [PGW-1:0]    rd_st;
    logic [PGW:0]      cs_end;
    logic              full, fits, merge_ok;
    logic [49:0]       add_sum;
    logic [32:0]       run_bytes;
    logic [LW+PG_SHIFT:0] want_bytes;

    assign aext     = {8'b0, addr_in_reg};
    assign full     = (count_reg >= CW'(QUEUE_DEPTH));
    assign run      = (left_reg < LW'(RUN_PAGES_MAX)) ? left_reg[LEN_BITS:0]
                                                      : (LEN_BITS+1)'(RUN_PAGES_MAX);
    assign run_bytes = {run, 12'b0};
    assign add_sum  = {1'b0, total_reg} + 50'(run_bytes);
    assign rd_st    = rdata[EW-1:LEN_BITS];
    assign rd_len   = {1'b0, rdata[LEN_BITS-1:0]} + 1'b1;
    assign fits     = ((LW+1)'(rd_len) >= want_reg);
    assign rem_len  = rd_len - want_reg[LEN_BITS:0];
    assign sa56     = 56'({rd_st, 12'b0});
    assign want_bytes = {want_reg, 12'b0};
    assign cs_end   = {1'b0, cs_reg} + (PGW+1)'(cl_reg);
    assign ml_sum   = cl_reg + rd_len;
    assign merge_ok = (cs_end == {1'b0, rd_st})
                      && ((LEN_BITS+2)'(cl_reg) + (LEN_BITS+2)'(rd_len)
                          <= (LEN_BITS+2)'(RUN_PAGES_MAX));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_DECODE;
            S_DECODE:
            begin
                if (op_reg == OP_FREE)
                begin
                    state_next = (addr_in_reg[PG_SHIFT-1:0] != '0
                                  || size_reg[PG_SHIFT-1:0] != '0) ? S_FIN : S_FRUN;
                end
                else
                begin
                    state_next = (size_reg == '0) ? S_FIN : S_ARD;
                end
            end
            S_FRUN:
            begin
                if (left_reg == '0)     state_next = S_FIN;
                else if (full && tried_reg) state_next = S_FIN;
                else if (full)          state_next = S_CSTART;
            end
            S_ARD:    state_next = (i_reg == n_reg) ? S_CSTART : S_ACMP;
            S_ACMP:   state_next = fits ? S_FIN : S_ARD;
            S_CSTART: state_next = (count_reg == '0) ? S_CDONE : S_SRD0;
            S_SRD0:   state_next = S_SLD0;
            S_SLD0:   state_next = S_SRD;
            S_SRD:    state_next = (i_reg == n_reg) ? S_SEND : S_SCMP;
            S_SCMP:   state_next = S_SRD;
            S_SEND:   state_next = swap_reg ? S_SRD0 : S_MRD0;
            S_MRD0:   state_next = S_MLD0;
            S_MLD0:   state_next = S_MRD;
            S_MRD:    state_next = (i_reg == n_reg) ? S_MEND : S_MCMP;
            S_MCMP:   state_next = S_MRD;
            S_MEND:   state_next = S_CDONE;
            S_CDONE:
            begin
                if (ret_reg == RET_FREE)  state_next = S_FRUN;
                else if (pass_reg == 1'b0) state_next = S_ARD;
                else                      state_next = S_FIN;
            end
            S_FIN:    if (!mvalid_reg || m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        head_next = head_reg;   tail_next = tail_reg;
        rp_next = rp_reg;       wp_next = wp_reg;
        count_next = count_reg; i_next = i_reg;
        n_next = n_reg;         k_next = k_reg;
        pass_next = pass_reg;   swap_next = swap_reg;
        tried_next = tried_reg; ret_next = ret_reg;
        total_next = total_reg; mvalid_next = mvalid_reg;
        op_next = op_reg;       addr_in_next = addr_in_reg;
        size_next = size_reg;   left_next = left_reg;
        pg_next = pg_reg;       cs_next = cs_reg;
        want_next = want_reg;   stat_next = stat_reg;
        aout_next = aout_reg;   cur_next = cur_reg;
        cl_next = cl_reg;       mad_next = mad_reg;
        mst_next = mst_reg;     mfb_next = mfb_reg;
        we = 1'b0; waddr = tail_reg; wdata = rdata; raddr = rp_reg;

        if (mvalid_reg && m_tready) mvalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next      = s_tuser;
                    addr_in_next = s_tdata[47:0];
                    size_next    = s_tdata[95:48];
                end
            end
            S_DECODE:
            begin
                aout_next  = '0;
                tried_next = 1'b0;
                pass_next  = 1'b0;
                stat_next  = ST_OK;
                left_next  = size_reg[FLD_BITS-1:PG_SHIFT];
                pg_next    = aext[PG_SHIFT +: PGW];
                want_next  = {1'b0, size_reg[FLD_BITS-1:PG_SHIFT]}
                             + (LW+1)'(size_reg[PG_SHIFT-1:0] != '0);
                i_next     = '0;
                n_next     = count_reg;
                rp_next    = head_reg;
                if (op_reg == OP_FREE)
                begin
                    ret_next = RET_FREE;
                    if (addr_in_reg[PG_SHIFT-1:0] != '0)      stat_next = ST_MISADDR;
                    else if (size_reg[PG_SHIFT-1:0] != '0)    stat_next = ST_MISSIZE;
                end
                else
                begin
                    ret_next = RET_ALLOC;
                    if (size_reg != '0) stat_next = ST_OOM;
                end
            end
            S_FRUN:
            begin
                if (left_reg != '0)
                begin
                    if (!full)
                    begin
                        we         = 1'b1;
                        waddr      = tail_reg;
                        wdata      = {pg_reg, run[LEN_BITS-1:0] - 1'b1};
                        tail_next  = inc(tail_reg);
                        count_next = count_reg + 1'b1;
                        total_next = (add_sum > 50'(TOTAL_MAX)) ? TOTAL_MAX
                                                                : add_sum[TOT_BITS-1:0];
                        pg_next    = pg_reg + PGW'(run);
                        left_next  = left_reg - LW'(run);
                        tried_next = 1'b0;
                    end
                    else if (tried_reg)
                    begin
                        stat_next = ST_OVF;
                    end
                    else
                    begin
                        tried_next = 1'b1;
                    end
                end
            end
            S_ARD:
            begin
                raddr = head_reg;
            end
            S_ACMP:
            begin
                if (fits)
                begin
                    aout_next = sa56[FLD_BITS-1:0];
                    stat_next = ST_OK;
                    total_next = (50'(total_reg) > 50'(want_bytes))
                                 ? TOT_BITS'(50'(total_reg) - 50'(want_bytes)) : '0;
                    if (rd_len != (LEN_BITS+1)'(want_reg))
                    begin
                        we    = 1'b1;
                        waddr = head_reg;
                        wdata = {rd_st + PGW'(want_reg[LEN_BITS:0]),
                                 rem_len[LEN_BITS-1:0] - 1'b1};
                    end
                    else
                    begin
                        head_next  = inc(head_reg);
                        count_next = count_reg - 1'b1;
                    end
                end
                else
                begin
                    we        = 1'b1;
                    waddr     = tail_reg;
                    wdata     = rdata;
                    head_next = inc(head_reg);
                    tail_next = inc(tail_reg);
                    i_next    = i_reg + 1'b1;
                end
            end
            S_CSTART:
            begin
                n_next    = count_reg;
                rp_next   = head_reg;
                swap_next = 1'b0;
            end
            S_SRD0:
            begin
                raddr     = rp_reg;
                swap_next = 1'b0;
            end
            S_SLD0:
            begin
                cur_next = rdata;
                wp_next  = rp_reg;
                rp_next  = inc(rp_reg);
                i_next   = CW'(1);
            end
            S_SRD:
            begin
                raddr = rp_reg;
            end
            S_SCMP:
            begin
                we    = 1'b1;
                waddr = wp_reg;
                if (cur_reg > rdata)
                begin
                    wdata     = rdata;
                    swap_next = 1'b1;
                end
                else
                begin
                    wdata    = cur_reg;
                    cur_next = rdata;
                end
                wp_next = rp_reg;
                rp_next = inc(rp_reg);
                i_next  = i_reg + 1'b1;
            end
            S_SEND:
            begin
                we      = 1'b1;
                waddr   = wp_reg;
                wdata   = cur_reg;
                rp_next = head_reg;
            end
            S_MRD0:
            begin
                raddr   = rp_reg;
                wp_next = head_reg;
            end
            S_MLD0:
            begin
                cs_next = rd_st;
                cl_next = rd_len;
                rp_next = inc(rp_reg);
                i_next  = CW'(1);
                k_next  = '0;
            end
            S_MRD:
            begin
                raddr = rp_reg;
            end
            S_MCMP:
            begin
                if (merge_ok)
                begin
                    cl_next = ml_sum;
                end
                else
                begin
                    we      = 1'b1;
                    waddr   = wp_reg;
                    wdata   = {cs_reg, cl_reg[LEN_BITS-1:0] - 1'b1};
                    wp_next = inc(wp_reg);
                    k_next  = k_reg + 1'b1;
                    cs_next = rd_st;
                    cl_next = rd_len;
                end
                rp_next = inc(rp_reg);
                i_next  = i_reg + 1'b1;
            end
            S_MEND:
            begin
                we         = 1'b1;
                waddr      = wp_reg;
                wdata      = {cs_reg, cl_reg[LEN_BITS-1:0] - 1'b1};
                tail_next  = inc(wp_reg);
                count_next = k_reg + 1'b1;
            end
            S_CDONE:
            begin
                if (ret_reg == RET_ALLOC && pass_reg == 1'b0)
                begin
                    pass_next = 1'b1;
                    i_next    = '0;
                    n_next    = count_reg;
                end
            end
            S_FIN:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mad_next    = aout_reg;
                    mst_next    = stat_reg;
                    mfb_next    = total_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            total_reg  <= '0;
            mvalid_reg <= 1'b0;
            rp_reg     <= '0;
            wp_reg     <= '0;
            i_reg      <= '0;
            n_reg      <= '0;
            k_reg      <= '0;
            pass_reg   <= 1'b0;
            swap_reg   <= 1'b0;
            tried_reg  <= 1'b0;
            ret_reg    <= RET_FREE;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            mvalid_reg <= mvalid_next;
            rp_reg     <= rp_next;
            wp_reg     <= wp_next;
            i_reg      <= i_next;
            n_reg      <= n_next;
            k_reg      <= k_next;
            pass_reg   <= pass_next;
            swap_reg   <= swap_next;
            tried_reg  <= tried_next;
            ret_reg    <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        addr_in_reg <= addr_in_next;
        size_reg    <= size_next;
        left_reg    <= left_next;
        pg_reg      <= pg_next;
        cs_reg      <= cs_next;
        want_reg    <= want_next;
        stat_reg    <= stat_next;
        aout_reg    <= aout_next;
        cur_reg     <= cur_next;
        cl_reg      <= cl_next;
        mad_reg     <= mad_next;
        mst_reg     <= mst_next;
        mfb_reg     <= mfb_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {4'b0, mfb_reg, mst_reg, mad_reg};

endmodule

// ----- src/fepa_ram.sv -----
module fepa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 56
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/fepa_chk.sv -----
`include "assert_macros.svh"

module fepa_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    `AST_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `AST_IMP(a_status_range, clk, rst_n, m_tvalid, m_tdata[50:48] <= 3'd4)
    `AST_IMP(a_fail_no_addr, clk, rst_n, m_tvalid && m_tdata[50:48] != 3'd0, m_tdata[47:0] == 48'd0)
    `AST_NXT(a_busy_after_take, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind free_extent_page_allocator fepa_chk u_fepa_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
